>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define TMA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tma assertion failed");

// Next-cycle implication, checked while out of reset.
`define TMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tma assertion failed");

`endif

>>> rtl/tma_pkg.sv
package tma_pkg;

  localparam int DEF_MAX_WINDOW   = 64;
  localparam int DEF_SAMPLE_WIDTH = 16;

  localparam int WL_W     = 7;   // window_length register
  localparam int SCALE_W  = 25;  // reciprocal_scale register
  localparam int CFG_W    = 25;  // widest register
  localparam int AVG_W    = 24;  // result width, Q8
  localparam int OUT_SHIFT = 16; // Q24 scale down to Q8

  localparam logic [WL_W-1:0]    WL_RESET    = 7'd1;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 25'h1000000;

  typedef enum logic [0:0] {
    CFG_WINDOW_LENGTH    = 1'b0,
    CFG_RECIPROCAL_SCALE = 1'b1
  } cfg_index_t;

endpackage

>>> rtl/tma_scaler.sv
module tma_scaler #(
  parameter int SOS_W = 29
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic                            in_valid,
  input  logic signed [SOS_W-1:0]         sos,
  input  logic [tma_pkg::SCALE_W-1:0]     scale,
  output logic                            res_valid,
  output logic signed [tma_pkg::AVG_W-1:0] res_average
);
  import tma_pkg::*;

  localparam int PW   = SOS_W + SCALE_W + 1;
  localparam int SH_W = PW - OUT_SHIFT;

  logic                   valid_r;
  logic signed [PW-1:0]   prod_r;
  logic signed [SH_W-1:0] shifted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= sos * $signed({1'b0, scale});
    end
  end

  // floor division by 2^16
  assign shifted   = prod_r[PW-1:OUT_SHIFT];
  assign res_valid = valid_r;

  generate
    if (SH_W > AVG_W) begin : g_sat
      logic all_ones;
      logic all_zeros;
      assign all_ones  = &shifted[SH_W-1:AVG_W-1];
      assign all_zeros = ~|shifted[SH_W-1:AVG_W-1];
      always_comb begin
        if (all_ones || all_zeros) begin
          res_average = shifted[AVG_W-1:0];
        end else if (shifted[SH_W-1]) begin
          res_average = {1'b1, {(AVG_W-1){1'b0}}};
        end else begin
          res_average = {1'b0, {(AVG_W-1){1'b1}}};
        end
      end
    end else begin : g_ext
      assign res_average = AVG_W'(shifted);
    end
  endgenerate

endmodule

>>> rtl/triangular_moving_average_core.sv
// An accepted word passes the second stage, c_valid_r, the scaler and out_valid_r.
// Throughput: one sample per cycle; the delay line and window-sum ring are read at
// accept, written back from the second stage, with forwarding when the window is 1.
// The pipeline only halts while a result sits in the output register under stall.
// Reset (synchronous, rst_n low) clears sums, position, count and valids; the
// memories are not cleared, warm-up gating keeps unwritten entries from being used.
module triangular_moving_average_core #(
  parameter int MAX_WINDOW   = tma_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_WIDTH = tma_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]     in_sample,
  input  logic                               in_start_of_series,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [tma_pkg::AVG_W-1:0]   out_average,
  input  logic                               cfg_write_enable,
  input  logic [0:0]                         cfg_index,
  input  logic [tma_pkg::CFG_W-1:0]          cfg_data
);
  import tma_pkg::*;
  `include "assert_macros.svh"

  localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WS_W  = SAMPLE_WIDTH + AW + 1;
  localparam int SOS_W = WS_W + AW;
  localparam int CMP_W = ((AW > WL_W) ? AW : WL_W) + 1;

  // configuration
  logic [WL_W-1:0]    window_length_r;
  logic [SCALE_W-1:0] scale_r;
  logic               cfg_wl_we;

  // series control
  logic [AW-1:0]      ring_position_r;
  logic [7:0]         samples_seen_r;
  logic signed [WS_W-1:0]  window_sum_r;
  logic signed [SOS_W-1:0] sum_of_sums_r;

  // memories
  logic signed [SAMPLE_WIDTH-1:0] delay_mem [MAX_WINDOW];
  logic signed [WS_W-1:0]         ring_mem  [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] dl_rd_r;
  logic signed [WS_W-1:0]         ws_rd_r;

  // second stage
  logic                           b_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] b_x_r;
  logic [AW-1:0]                  b_pos_r;
  logic                           b_start_r;
  logic                           b_old_x_r;
  logic                           b_ring_we_r;
  logic                           b_old_ws_r;
  logic                           b_emit_r;
  logic                           b_fwd_x_r;
  logic                           b_fwd_ws_r;
  logic signed [SAMPLE_WIDTH-1:0] fwd_x_r;
  logic signed [WS_W-1:0]         fwd_ws_r;

  logic                           c_valid_r;
  logic                           d_valid;
  logic signed [AVG_W-1:0]        d_average;
  logic                           out_valid_r;
  logic signed [AVG_W-1:0]        out_average_r;

  logic                adv;
  logic                accept;
  logic [WL_W-1:0]     k_eff;
  logic [AW-1:0]       pos_cur;
  logic [AW-1:0]       pos_nxt;
  logic [7:0]          s_cur;
  logic [8:0]          s9;
  logic [8:0]          k9;
  logic [8:0]          twok9;
  logic                fwd_hit;

  logic signed [SAMPLE_WIDTH-1:0] old_x;
  logic signed [WS_W-1:0]         old_ws;
  logic signed [WS_W-1:0]         ws_base;
  logic signed [SOS_W-1:0]        sos_base;
  logic signed [WS_W-1:0]         ws_nxt;
  logic signed [SOS_W-1:0]        sos_nxt;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;
  assign cfg_wl_we = cfg_write_enable && (cfg_index == CFG_WINDOW_LENGTH);

  always_comb begin
    if (window_length_r == '0) begin
      k_eff = WL_W'(1);
    end else if (32'(window_length_r) > MAX_WINDOW) begin
      k_eff = WL_W'(MAX_WINDOW);
    end else begin
      k_eff = window_length_r;
    end
  end

  always_comb begin
    if (in_start_of_series ||
        (CMP_W'(ring_position_r) >= CMP_W'(k_eff))) begin
      pos_cur = '0;
    end else begin
      pos_cur = ring_position_r;
    end
    if (CMP_W'(pos_cur) + CMP_W'(1) >= CMP_W'(k_eff)) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_cur + AW'(1);
    end
    s_cur = in_start_of_series ? 8'd0 : samples_seen_r;
    s9    = {1'b0, s_cur};
    k9    = 9'(k_eff);
    twok9 = {1'b0, k_eff, 1'b0};
  end

  // k = 1 or a start flag: the word in the second stage writes the entry being read now
  assign fwd_hit = b_valid_r && (b_pos_r == pos_cur);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= WL_RESET;
      scale_r         <= SCALE_RESET;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        CFG_WINDOW_LENGTH:    window_length_r <= cfg_data[WL_W-1:0];
        CFG_RECIPROCAL_SCALE: scale_r         <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wl_we) begin
      ring_position_r <= '0;
      samples_seen_r  <= '0;
    end else if (accept) begin
      ring_position_r <= pos_nxt;
      samples_seen_r  <= (s_cur == 8'hFF) ? s_cur : s_cur + 8'd1;
    end
  end

  // read side of the memories
  always_ff @(posedge clk) begin
    if (accept) begin
      dl_rd_r <= delay_mem[pos_cur];
      ws_rd_r <= ring_mem[pos_cur];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_x_r       <= in_sample;
      b_pos_r     <= pos_cur;
      b_start_r   <= in_start_of_series;
      b_old_x_r   <= s9 >= k9;
      b_ring_we_r <= s9 + 9'd1 >= k9;
      b_old_ws_r  <= s9 + 9'd1 >= twok9;
      b_emit_r    <= s9 + 9'd2 >= twok9;
      b_fwd_x_r   <= fwd_hit;
      b_fwd_ws_r  <= fwd_hit && b_ring_we_r;
      fwd_x_r     <= b_x_r;
      fwd_ws_r    <= ws_nxt;
    end
  end

  always_comb begin
    if (!b_old_x_r) begin
      old_x = '0;
    end else if (b_fwd_x_r) begin
      old_x = fwd_x_r;
    end else begin
      old_x = dl_rd_r;
    end
    if (!b_old_ws_r) begin
      old_ws = '0;
    end else if (b_fwd_ws_r) begin
      old_ws = fwd_ws_r;
    end else begin
      old_ws = ws_rd_r;
    end
    ws_base  = b_start_r ? '0 : window_sum_r;
    sos_base = b_start_r ? '0 : sum_of_sums_r;
    ws_nxt   = ws_base + WS_W'(b_x_r) - WS_W'(old_x);
    sos_nxt  = b_ring_we_r ? (sos_base + SOS_W'(ws_nxt) - SOS_W'(old_ws)) : sos_base;
  end

  // write-back
  always_ff @(posedge clk) begin
    if (adv && b_valid_r) begin
      delay_mem[b_pos_r] <= b_x_r;
      if (b_ring_we_r) begin
        ring_mem[b_pos_r] <= ws_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wl_we) begin
      window_sum_r  <= '0;
      sum_of_sums_r <= '0;
    end else if (adv && b_valid_r) begin
      window_sum_r  <= ws_nxt;
      sum_of_sums_r <= sos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (adv) begin
      c_valid_r <= b_valid_r && b_emit_r;
    end
  end

  tma_scaler #(
    .SOS_W(SOS_W)
  ) u_scaler (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid    (c_valid_r),
    .sos         (sum_of_sums_r),
    .scale       (scale_r),
    .res_valid   (d_valid),
    .res_average (d_average)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_average_r <= d_average;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;

  // a start flag can land on the entry just written, but then nothing old is read
  `TMA_ASSERT_NOW(a_pos_in_window, clk, rst_n, 1'b1,
    CMP_W'(ring_position_r) < CMP_W'(k_eff))
  `TMA_ASSERT_NOW(a_fwd_only_unit_window, clk, rst_n, b_valid_r && b_fwd_x_r && b_old_x_r,
    k_eff == WL_W'(1))
  `TMA_ASSERT_NEXT(a_result_reaches_output, clk, rst_n, adv && d_valid,
    out_valid_r)

endmodule
